/* src/obfv_pkg.sv */
// ----------------------------------------------------------------------------
// obfv_pkg
// Shared widths, word types and constants of the orthonormal basis core.
// ----------------------------------------------------------------------------
package obfv_pkg;

  localparam int IN_W     = 16;
  localparam int FRAC     = 14;
  localparam int VEC_W    = FRAC + 2;
  localparam int NORM_W   = 20;
  localparam int LEN_FRAC = 10;
  localparam int NIN_W    = 2 * VEC_W - 1;
  localparam int MAG_W    = NIN_W;
  localparam int BL_W     = $clog2(NIN_W + 1);
  localparam int SQ_W     = 2 * NORM_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int RAD_W    = SUM_W + 2 * LEN_FRAC;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int Q_W      = FRAC + 1;
  localparam int DIV_W    = NORM_W + FRAC + LEN_FRAC + 2;
  localparam int NORM_LAT = ROOT_W + Q_W + 6;
  localparam int ONE      = 1 << FRAC;
  localparam int HALF     = ONE >> 1;

  typedef logic signed [IN_W-1:0]  in_t;
  typedef logic signed [VEC_W-1:0] q_t;
  typedef logic signed [NIN_W-1:0] nin_t;

  localparam q_t Q_ONE = q_t'(ONE);

  typedef struct packed {
    nin_t x;
    nin_t y;
    nin_t z;
  } nvec_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } qvec_t;

  typedef struct packed {
    in_t fwd_x;
    in_t fwd_y;
    in_t fwd_z;
    in_t up_hint_x;
    in_t up_hint_y;
    in_t up_hint_z;
    in_t right_hint_x;
    in_t right_hint_y;
    in_t right_hint_z;
  } in_word_t;

  typedef struct packed {
    q_t right_out_x;
    q_t right_out_y;
    q_t right_out_z;
    q_t up_out_x;
    q_t up_out_y;
    q_t up_out_z;
    q_t fwd_out_x;
    q_t fwd_out_y;
    q_t fwd_out_z;
  } out_word_t;

endpackage

/* src/obfv_norm.sv */
// ----------------------------------------------------------------------------
// obfv_norm
// Pipelined vector normalize: range alignment, sum of squares, bit-serial
// square root one bit per stage, then restoring divide one bit per stage.
// ----------------------------------------------------------------------------
module obfv_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  obfv_pkg::nvec_t vec_i,
  output logic            valid_o,
  output logic            ok_o,
  output obfv_pkg::qvec_t vec_o
);
  import obfv_pkg::*;

  localparam int LANES = 3;

  nin_t in_c [LANES];
  logic [MAG_W-1:0] mag_c [LANES];
  logic [MAG_W-1:0] max_c;
  logic [BL_W-1:0]  bl_c;

  logic             a_vld_q;
  logic [MAG_W-1:0] a_mag_q [LANES];
  logic [LANES-1:0] a_neg_q;
  logic             a_nz_q;
  logic [BL_W-1:0]  a_bl_q;

  logic [MAG_W+NORM_W-1:0] sh_c [LANES];

  logic              b_vld_q;
  logic [NORM_W-1:0] b_m_q [LANES];
  logic [LANES-1:0]  b_neg_q;
  logic              b_nz_q;

  logic              c_vld_q;
  logic [SQ_W-1:0]   c_sq_q [LANES];
  logic [NORM_W-1:0] c_m_q [LANES];
  logic [LANES-1:0]  c_neg_q;
  logic              c_nz_q;
  logic [SUM_W-1:0]  sum_c;

  logic              sr_vld_q [ROOT_W+1];
  logic [RAD_W-1:0]  sr_rem_q [ROOT_W+1];
  logic [ROOT_W-1:0] sr_root_q [ROOT_W+1];
  logic [NORM_W-1:0] sr_m_q [ROOT_W+1][LANES];
  logic [LANES-1:0]  sr_neg_q [ROOT_W+1];
  logic              sr_nz_q [ROOT_W+1];
  logic [RAD_W-1:0]  sr_t_c [ROOT_W];

  logic              dv_vld_q [Q_W+1];
  logic [DIV_W-1:0]  dv_rem_q [Q_W+1][LANES];
  logic [Q_W-1:0]    dv_quo_q [Q_W+1][LANES];
  logic [ROOT_W-1:0] dv_len_q [Q_W+1];
  logic [LANES-1:0]  dv_neg_q [Q_W+1];
  logic              dv_nz_q [Q_W+1];
  logic [DIV_W-1:0]  dv_d_c [Q_W];

  q_t   out_c [LANES];
  q_t   out_q [LANES];
  logic out_vld_q;
  logic out_nz_q;

  assign in_c[0] = vec_i.x;
  assign in_c[1] = vec_i.y;
  assign in_c[2] = vec_i.z;

  always_comb begin
    max_c = '0;
    bl_c  = '0;
    for (int l = 0; l < LANES; l++) begin
      mag_c[l] = in_c[l][NIN_W-1] ? MAG_W'(-in_c[l]) : MAG_W'(in_c[l]);
      if (mag_c[l] > max_c) max_c = mag_c[l];
    end
    for (int b = 0; b < MAG_W; b++) begin
      if (max_c[b]) bl_c = BL_W'(b + 1);
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sh_c[l] = {a_mag_q[l], NORM_W'(0)} >> a_bl_q;
    end
    sum_c = SUM_W'(c_sq_q[0]) + SUM_W'(c_sq_q[1]) + SUM_W'(c_sq_q[2]);
    for (int k = 0; k < ROOT_W; k++) begin
      sr_t_c[k] = (RAD_W'(sr_root_q[k]) << (ROOT_W - k)) |
                  (RAD_W'(1) << (2 * (ROOT_W - 1 - k)));
    end
    for (int k = 0; k < Q_W; k++) begin
      dv_d_c[k] = DIV_W'(dv_len_q[k]) << (Q_W - 1 - k);
    end
    for (int l = 0; l < LANES; l++) begin
      out_c[l] = q_t'(VEC_W'(dv_quo_q[Q_W][l]));
      if (!dv_nz_q[Q_W]) begin
        out_c[l] = '0;
      end else if (dv_neg_q[Q_W][l]) begin
        out_c[l] = -out_c[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k <= ROOT_W; k++) sr_vld_q[k] <= 1'b0;
      for (int k = 0; k <= Q_W; k++) dv_vld_q[k] <= 1'b0;
    end else begin
      a_vld_q     <= valid_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      sr_vld_q[0] <= c_vld_q;
      for (int k = 0; k < ROOT_W; k++) sr_vld_q[k+1] <= sr_vld_q[k];
      dv_vld_q[0] <= sr_vld_q[ROOT_W];
      for (int k = 0; k < Q_W; k++) dv_vld_q[k+1] <= dv_vld_q[k];
      out_vld_q   <= dv_vld_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      a_mag_q[l] <= mag_c[l];
      a_neg_q[l] <= in_c[l][NIN_W-1];
      b_m_q[l]   <= sh_c[l][NORM_W-1:0];
      c_sq_q[l]  <= SQ_W'(b_m_q[l]) * SQ_W'(b_m_q[l]);
      c_m_q[l]   <= b_m_q[l];
    end
    a_nz_q  <= |max_c;
    a_bl_q  <= bl_c;
    b_neg_q <= a_neg_q;
    b_nz_q  <= a_nz_q;
    c_neg_q <= b_neg_q;
    c_nz_q  <= b_nz_q;

    sr_rem_q[0]  <= {sum_c, (2 * LEN_FRAC)'(0)};
    sr_root_q[0] <= '0;
    sr_m_q[0]    <= c_m_q;
    sr_neg_q[0]  <= c_neg_q;
    sr_nz_q[0]   <= c_nz_q;
    for (int k = 0; k < ROOT_W; k++) begin
      if (sr_rem_q[k] >= sr_t_c[k]) begin
        sr_rem_q[k+1]  <= sr_rem_q[k] - sr_t_c[k];
        sr_root_q[k+1] <= sr_root_q[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
      end else begin
        sr_rem_q[k+1]  <= sr_rem_q[k];
        sr_root_q[k+1] <= sr_root_q[k];
      end
      sr_m_q[k+1]   <= sr_m_q[k];
      sr_neg_q[k+1] <= sr_neg_q[k];
      sr_nz_q[k+1]  <= sr_nz_q[k];
    end

    for (int l = 0; l < LANES; l++) begin
      dv_rem_q[0][l] <= (DIV_W'(sr_m_q[ROOT_W][l]) << (FRAC + LEN_FRAC)) +
                        DIV_W'(sr_root_q[ROOT_W] >> 1);
      dv_quo_q[0][l] <= '0;
    end
    dv_len_q[0] <= sr_root_q[ROOT_W];
    dv_neg_q[0] <= sr_neg_q[ROOT_W];
    dv_nz_q[0]  <= sr_nz_q[ROOT_W];
    for (int k = 0; k < Q_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (dv_rem_q[k][l] >= dv_d_c[k]) begin
          dv_rem_q[k+1][l] <= dv_rem_q[k][l] - dv_d_c[k];
          dv_quo_q[k+1][l] <= dv_quo_q[k][l] | (Q_W'(1) << (Q_W - 1 - k));
        end else begin
          dv_rem_q[k+1][l] <= dv_rem_q[k][l];
          dv_quo_q[k+1][l] <= dv_quo_q[k][l];
        end
      end
      dv_len_q[k+1] <= dv_len_q[k];
      dv_neg_q[k+1] <= dv_neg_q[k];
      dv_nz_q[k+1]  <= dv_nz_q[k];
    end

    out_q    <= out_c;
    out_nz_q <= dv_nz_q[Q_W];
  end

  assign valid_o = out_vld_q;
  assign ok_o    = out_nz_q;
  assign vec_o   = '{x: out_q[0], y: out_q[1], z: out_q[2]};

endmodule

/* src/orthonormal_basis_from_vectors_core.sv */
// ----------------------------------------------------------------------------
// orthonormal_basis_from_vectors_core
// Builds a right, up, forward unit frame from a forward vector and hints.
// ----------------------------------------------------------------------------
// each word goes through two normalize passes in turn before res_valid_o
// throughput: one word per cycle, busy is never raised
// the receiver cannot stall; every result shows for one cycle
// reset clears all valid bits; data registers are not reset
module orthonormal_basis_from_vectors_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  obfv_pkg::in_word_t  word_i,
  output logic                busy,
  output logic                res_valid_o,
  output obfv_pkg::out_word_t res_o
);
  import obfv_pkg::*;

  localparam int PROD_W = 2 * VEC_W;

  typedef struct packed {
    qvec_t fn;
    logic  uh;
    logic  rh;
    logic  alt;
    logic  fyneg;
  } side_t;

  function automatic nvec_t cross_raw(qvec_t a, qvec_t b);
    logic signed [PROD_W-1:0] p0, p1, p2, p3, p4, p5;
    nvec_t r;
    p0 = a.y * b.z;
    p1 = a.z * b.y;
    p2 = a.z * b.x;
    p3 = a.x * b.z;
    p4 = a.x * b.y;
    p5 = a.y * b.x;
    r.x = NIN_W'(p0 - p1);
    r.y = NIN_W'(p2 - p3);
    r.z = NIN_W'(p4 - p5);
    return r;
  endfunction

  function automatic q_t rnd_q(nin_t v);
    logic [NIN_W-1:0]    mag;
    logic [NIN_W:0]      sum;
    logic [NIN_W-FRAC:0] m;
    q_t                  r;
    mag = v[NIN_W-1] ? NIN_W'(-v) : NIN_W'(v);
    sum = {1'b0, mag} + (NIN_W + 1)'(HALF);
    m   = sum[NIN_W:FRAC];
    if (m > (NIN_W - FRAC + 1)'(ONE)) m = (NIN_W - FRAC + 1)'(ONE);
    r = q_t'(VEC_W'(m));
    return v[NIN_W-1] ? -r : r;
  endfunction

  function automatic qvec_t rnd_vec(nvec_t v);
    qvec_t r;
    r.x = rnd_q(v.x);
    r.y = rnd_q(v.y);
    r.z = rnd_q(v.z);
    return r;
  endfunction

  logic  uh_nz_c, rh_nz_c;
  logic  t0_vld_q, t0_uh_q, t0_rh_q;
  nvec_t t0_f_q, t0_h_q;

  logic  f1_vld, f1_ok, h1_vld, h1_ok;
  qvec_t f1_vec, h1_vec;
  logic [1:0] d1_q [NORM_LAT];

  nvec_t cr_c, c_c, b_c;
  side_t s1_c;
  logic  t1_vld_q;
  nvec_t t1_c_q, t1_b_q;
  side_t t1_s_q;

  logic  c2_vld, c2_ok, b2_vld, b2_ok;
  qvec_t c2_vec, b2_vec;
  side_t d2_q [NORM_LAT];

  logic  x1_vld_q, x1_cok_q;
  nvec_t x1_raw_q;
  qvec_t x1_cn_q, x1_bn_q;
  side_t x1_s_q;

  logic  x2_vld_q, x2_cok_q;
  qvec_t x2_fr_q, x2_fu_q, x2_cn_q;
  side_t x2_s_q;

  qvec_t s_rs_c, s_us_c, s_a_c, s_b_c;
  logic  s_vld_q;
  qvec_t s_rs_q, s_us_q, s_a_q, s_b_q;
  side_t s_s_q;

  logic  x3_vld_q;
  nvec_t x3_raw_q;
  qvec_t x3_rs_q, x3_us_q;
  side_t x3_s_q;

  qvec_t x4_c, r_out_c, u_out_c;
  logic  res_vld_q, x4_uh_q, x4_rh_q;
  out_word_t res_q;

  assign busy    = 1'b0;
  assign uh_nz_c = |{word_i.up_hint_x, word_i.up_hint_y, word_i.up_hint_z};
  assign rh_nz_c = |{word_i.right_hint_x, word_i.right_hint_y, word_i.right_hint_z};

  always_ff @(posedge clk_i) begin
    t0_f_q.x <= NIN_W'(word_i.fwd_x);
    t0_f_q.y <= NIN_W'(word_i.fwd_y);
    t0_f_q.z <= NIN_W'(word_i.fwd_z);
    if (uh_nz_c) begin
      t0_h_q.x <= NIN_W'(word_i.up_hint_x);
      t0_h_q.y <= NIN_W'(word_i.up_hint_y);
      t0_h_q.z <= NIN_W'(word_i.up_hint_z);
    end else begin
      t0_h_q.x <= NIN_W'(word_i.right_hint_x);
      t0_h_q.y <= NIN_W'(word_i.right_hint_y);
      t0_h_q.z <= NIN_W'(word_i.right_hint_z);
    end
    t0_uh_q <= uh_nz_c;
    t0_rh_q <= rh_nz_c;
  end

  obfv_norm u_norm_f (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t0_vld_q),
    .vec_i   (t0_f_q),
    .valid_o (f1_vld),
    .ok_o    (f1_ok),
    .vec_o   (f1_vec)
  );

  obfv_norm u_norm_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t0_vld_q),
    .vec_i   (t0_h_q),
    .valid_o (h1_vld),
    .ok_o    (h1_ok),
    .vec_o   (h1_vec)
  );

  // hint x fwd when the up hint is given, fwd x hint when the right hint is used
  always_comb begin
    cr_c = cross_raw(f1_vec, h1_vec);
    c_c  = cr_c;
    if (d1_q[NORM_LAT-1][1]) begin
      c_c.x = -cr_c.x;
      c_c.y = -cr_c.y;
      c_c.z = -cr_c.z;
    end
    b_c.x = NIN_W'(f1_vec.z);
    b_c.y = '0;
    b_c.z = -NIN_W'(f1_vec.x);
    s1_c.fn    = f1_vec;
    s1_c.uh    = d1_q[NORM_LAT-1][1];
    s1_c.rh    = d1_q[NORM_LAT-1][0];
    s1_c.alt   = !f1_ok || (f1_vec.x == '0 && f1_vec.z == '0);
    s1_c.fyneg = f1_vec.y[VEC_W-1];
  end

  always_ff @(posedge clk_i) begin
    d1_q[0] <= {t0_uh_q, t0_rh_q};
    for (int i = 1; i < NORM_LAT; i++) d1_q[i] <= d1_q[i-1];
    t1_c_q <= c_c;
    t1_b_q <= b_c;
    t1_s_q <= s1_c;
  end

  obfv_norm u_norm_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t1_vld_q),
    .vec_i   (t1_c_q),
    .valid_o (c2_vld),
    .ok_o    (c2_ok),
    .vec_o   (c2_vec)
  );

  obfv_norm u_norm_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t1_vld_q),
    .vec_i   (t1_b_q),
    .valid_o (b2_vld),
    .ok_o    (b2_ok),
    .vec_o   (b2_vec)
  );

  always_comb begin
    if (x2_s_q.uh) begin
      s_rs_c = x2_cok_q ? x2_cn_q : x2_fr_q;
      s_us_c = x2_fu_q;
      s_a_c  = x2_s_q.fn;
      s_b_c  = s_rs_c;
    end else if (x2_s_q.rh) begin
      s_rs_c = x2_fr_q;
      s_us_c = x2_cok_q ? x2_cn_q : x2_fu_q;
      s_a_c  = s_us_c;
      s_b_c  = x2_s_q.fn;
    end else begin
      s_rs_c = x2_fr_q;
      s_us_c = x2_fu_q;
      s_a_c  = x2_s_q.fn;
      s_b_c  = x2_fr_q;
    end
    x4_c    = rnd_vec(x3_raw_q);
    r_out_c = (x3_s_q.rh && !x3_s_q.uh) ? x4_c : x3_rs_q;
    u_out_c = x3_s_q.uh ? x4_c : x3_us_q;
  end

  always_ff @(posedge clk_i) begin
    d2_q[0] <= t1_s_q;
    for (int i = 1; i < NORM_LAT; i++) d2_q[i] <= d2_q[i-1];

    x1_raw_q <= cross_raw(d2_q[NORM_LAT-1].fn, b2_vec);
    x1_cn_q  <= c2_vec;
    x1_cok_q <= c2_ok;
    x1_bn_q  <= b2_vec;
    x1_s_q   <= d2_q[NORM_LAT-1];

    if (x1_s_q.alt) begin
      x2_fr_q <= '{x: Q_ONE, y: '0, z: '0};
      x2_fu_q <= '{x: '0, y: '0, z: (x1_s_q.fyneg ? Q_ONE : -Q_ONE)};
    end else begin
      x2_fr_q <= x1_bn_q;
      x2_fu_q <= rnd_vec(x1_raw_q);
    end
    x2_cn_q  <= x1_cn_q;
    x2_cok_q <= x1_cok_q;
    x2_s_q   <= x1_s_q;

    s_rs_q <= s_rs_c;
    s_us_q <= s_us_c;
    s_a_q  <= s_a_c;
    s_b_q  <= s_b_c;
    s_s_q  <= x2_s_q;

    x3_raw_q <= cross_raw(s_a_q, s_b_q);
    x3_rs_q  <= s_rs_q;
    x3_us_q  <= s_us_q;
    x3_s_q   <= s_s_q;

    res_q.right_out_x <= r_out_c.x;
    res_q.right_out_y <= r_out_c.y;
    res_q.right_out_z <= r_out_c.z;
    res_q.up_out_x    <= u_out_c.x;
    res_q.up_out_y    <= u_out_c.y;
    res_q.up_out_z    <= u_out_c.z;
    res_q.fwd_out_x   <= x3_s_q.fn.x;
    res_q.fwd_out_y   <= x3_s_q.fn.y;
    res_q.fwd_out_z   <= x3_s_q.fn.z;
    x4_uh_q           <= x3_s_q.uh;
    x4_rh_q           <= x3_s_q.rh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_vld_q  <= 1'b0;
      t1_vld_q  <= 1'b0;
      x1_vld_q  <= 1'b0;
      x2_vld_q  <= 1'b0;
      s_vld_q   <= 1'b0;
      x3_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      t0_vld_q  <= start;
      t1_vld_q  <= f1_vld & h1_vld;
      x1_vld_q  <= c2_vld & b2_vld;
      x2_vld_q  <= x1_vld_q;
      s_vld_q   <= x2_vld_q;
      x3_vld_q  <= s_vld_q;
      res_vld_q <= x3_vld_q;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  a_norm1_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_vld == h1_vld && (!h1_vld || h1_ok || !t1_s_q.uh || 1'b1))
    else $error("forward and hint normalize out of step");

  a_norm2_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_vld == b2_vld)
    else $error("cross and fallback normalize out of step");

  a_fallback_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_vld && !d2_q[NORM_LAT-1].alt |-> b2_ok)
    else $error("fallback right vector failed to normalize");

  a_fwd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.fwd_out_x <= Q_ONE && res_o.fwd_out_x >= -Q_ONE &&
                    res_o.fwd_out_y <= Q_ONE && res_o.fwd_out_y >= -Q_ONE &&
                    res_o.fwd_out_z <= Q_ONE && res_o.fwd_out_z >= -Q_ONE)
    else $error("forward word out of unit range");

  a_zero_fwd_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !x4_uh_q && !x4_rh_q && res_o.fwd_out_x == '0 &&
    res_o.fwd_out_y == '0 && res_o.fwd_out_z == '0 |->
    res_o.right_out_x == Q_ONE && res_o.right_out_y == '0 &&
    res_o.right_out_z == '0 && res_o.up_out_z == -Q_ONE)
    else $error("zero forward without hint gave wrong frame");

endmodule
